>>> design/assert_macros.svh
// Assertion helpers used by the datapath module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checked on every rising clock edge, also during reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`endif

>>> design/deq_pkg.sv
package deq_pkg;

  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned OP_W = 3;
  localparam int unsigned FLAG_W = 3;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

  typedef struct packed {
    logic take;
    logic exec;
    logic refill;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic needs_refill;
    logic out_free;
  } sts_t;

endpackage

>>> design/double_ended_queue_unit.sv
// Channel  Direction  tdata                          tuser
// s_axis   in         push_value                     op
// m_axis   out        popped_value, entry_count,     popped_valid, is_empty,
//                     front_value, back_value        overflow
//
// An item is held from acceptance until its result is loaded; no new item is
// accepted before then. A pop that leaves words behind passes through an extra
// wait state, since the new end word is fetched from the word store with a
// registered read. The result is loaded once the output register is free.
// Head and count are reset to an empty queue; the cached end words and the
// store itself are not cleared.
// A result waits in the output register while the next word is accepted; a
// further result is held back until that register is taken.
module double_ended_queue_unit #(
  parameter int unsigned DEPTH         = deq_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS     = deq_pkg::WORD_BITS_DEF,
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1),
  localparam int unsigned IN_TDATA_W   = ((WORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_RAW_W    = 3 * WORD_BITS + CNT_W,
  localparam int unsigned OUT_TDATA_W  = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // push_value
  input  logic [IN_TDATA_W-1:0]      s_axis_tdata,
  // op
  input  logic [deq_pkg::OP_W-1:0]   s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // popped_value, entry_count, front_value, back_value
  output logic [OUT_TDATA_W-1:0]     m_axis_tdata,
  // popped_valid, is_empty, overflow
  output logic [deq_pkg::FLAG_W-1:0] m_axis_tuser
);

  deq_pkg::cmd_t        cmd;
  deq_pkg::sts_t        sts;
  logic [WORD_BITS-1:0] popped;
  logic [CNT_W-1:0]     count;
  logic [WORD_BITS-1:0] front;
  logic [WORD_BITS-1:0] back;

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  deq_dpath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (s_axis_tuser),
    .in_word_i    (s_axis_tdata[WORD_BITS-1:0]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_popped_o (popped),
    .out_count_o  (count),
    .out_front_o  (front),
    .out_back_o   (back),
    .out_flags_o  (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TDATA_W'({back, front, count, popped});

endmodule

>>> design/deq_ctrl.sv
module deq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  deq_pkg::sts_t sts_i,
  output deq_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.needs_refill ? ST_WAIT : ST_DONE;
      end
      ST_WAIT: begin
        cmd_o.refill = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/deq_dpath.sv
`include "assert_macros.svh"

module deq_dpath #(
  parameter int unsigned DEPTH     = deq_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = deq_pkg::WORD_BITS_DEF,
  localparam int unsigned IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  deq_pkg::cmd_t               cmd_i,
  output deq_pkg::sts_t               sts_o,
  input  logic [deq_pkg::OP_W-1:0]    in_op_i,
  input  logic [WORD_BITS-1:0]        in_word_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [WORD_BITS-1:0]        out_popped_o,
  output logic [CNT_W-1:0]            out_count_o,
  output logic [WORD_BITS-1:0]        out_front_o,
  output logic [WORD_BITS-1:0]        out_back_o,
  output logic [deq_pkg::FLAG_W-1:0]  out_flags_o
);

  localparam int unsigned SUM_W = IDX_W + 1;

  logic [WORD_BITS-1:0] mem [DEPTH];

  logic [deq_pkg::OP_W-1:0] op_q;
  logic [WORD_BITS-1:0]     word_q;
  logic [IDX_W-1:0]         head_q, head_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [WORD_BITS-1:0]     front_q, front_d;
  logic [WORD_BITS-1:0]     back_q, back_d;
  logic [WORD_BITS-1:0]     popped_q, popped_d;
  logic                     pvalid_q, pvalid_d;
  logic                     ovf_q, ovf_d;
  logic [WORD_BITS-1:0]     rd_q;
  logic                     out_valid_q;

  logic                     we;
  logic [IDX_W-1:0]         wa;
  logic [IDX_W-1:0]         ra;
  logic                     is_full;
  logic                     is_empty;
  logic [IDX_W-1:0]         head_inc;
  logic [IDX_W-1:0]         head_dec;
  logic [IDX_W-1:0]         tail_pos;
  logic [IDX_W-1:0]         prev_back_pos;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] pos);
    logic [SUM_W-1:0] adj;
    adj = (pos >= SUM_W'(DEPTH)) ? (pos - SUM_W'(DEPTH)) : pos;
    return adj[IDX_W-1:0];
  endfunction

  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);

  assign head_inc      = wrap_idx(SUM_W'(head_q) + SUM_W'(1));
  assign head_dec      = (head_q == '0) ? IDX_W'(DEPTH - 1) : (head_q - IDX_W'(1));
  assign tail_pos      = wrap_idx(SUM_W'(head_q) + SUM_W'(count_q));
  assign prev_back_pos = wrap_idx(SUM_W'(head_q) + SUM_W'(count_q) - SUM_W'(2));

  assign sts_o.needs_refill = ((op_q == deq_pkg::OP_POP_FRONT) ||
                               (op_q == deq_pkg::OP_POP_BACK)) &&
                              (count_q > CNT_W'(1));
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    front_d  = front_q;
    back_d   = back_q;
    popped_d = popped_q;
    pvalid_d = pvalid_q;
    ovf_d    = ovf_q;
    we       = 1'b0;
    wa       = head_q;
    ra       = head_q;
    if (cmd_i.exec) begin
      popped_d = '0;
      pvalid_d = 1'b0;
      ovf_d    = 1'b0;
      case (op_q)
        deq_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            ovf_d = 1'b1;
          end else begin
            head_d  = head_dec;
            we      = 1'b1;
            wa      = head_dec;
            count_d = count_q + CNT_W'(1);
            front_d = word_q;
            if (is_empty) begin
              back_d = word_q;
            end
          end
        end
        deq_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            ovf_d = 1'b1;
          end else begin
            we      = 1'b1;
            wa      = tail_pos;
            count_d = count_q + CNT_W'(1);
            back_d  = word_q;
            if (is_empty) begin
              front_d = word_q;
            end
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (!is_empty) begin
            popped_d = front_q;
            pvalid_d = 1'b1;
            head_d   = head_inc;
            count_d  = count_q - CNT_W'(1);
            ra       = head_inc;
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (!is_empty) begin
            popped_d = back_q;
            pvalid_d = 1'b1;
            count_d  = count_q - CNT_W'(1);
            ra       = prev_back_pos;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.refill) begin
      if (op_q == deq_pkg::OP_POP_FRONT) begin
        front_d = rd_q;
      end else begin
        back_d = rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= word_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q   <= in_op_i;
      word_q <= in_word_i;
    end
    front_q  <= front_d;
    back_q   <= back_d;
    popped_q <= popped_d;
    pvalid_q <= pvalid_d;
    ovf_q    <= ovf_d;
    if (cmd_i.load) begin
      out_popped_o <= popped_q;
      out_count_o  <= count_q;
      out_front_o  <= is_empty ? '0 : front_q;
      out_back_o   <= is_empty ? '0 : back_q;
      out_flags_o  <= {ovf_q, is_empty, pvalid_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_RST(a_count_bound, count_q <= CNT_W'(DEPTH))
  `ASSERT_RST(a_hold_when_idle, !cmd_i.exec |=> $stable(count_q) && $stable(head_q))
  `ASSERT_RST(a_load_free, cmd_i.load |-> sts_o.out_free)
  `ASSERT_RST(a_refill_pop, cmd_i.refill |->
              (op_q == deq_pkg::OP_POP_FRONT) || (op_q == deq_pkg::OP_POP_BACK))

endmodule
